>>> hw/rtl/mhgb_pkg.sv
`default_nettype none
package mhgb_pkg;

   // command codes on req_cmd
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   // result status codes
   localparam logic [2:0] STS_UPDATED    = 3'd0;
   localparam logic [2:0] STS_NOT_HIGHER = 3'd1;
   localparam logic [2:0] STS_INVALID    = 3'd2;
   localparam logic [2:0] STS_TOO_FAR    = 3'd3;
   localparam logic [2:0] STS_HEIGHT_OUT = 3'd4;
   localparam logic [2:0] STS_OFF_GRID   = 3'd5;
   localparam logic [2:0] STS_READ       = 3'd6;
   localparam logic [2:0] STS_CLEARED    = 3'd7;

   // register indexes on the csr port
   localparam logic [2:0] REG_MAX_DIST   = 3'd0;
   localparam logic [2:0] REG_MIN_ELEV   = 3'd1;
   localparam logic [2:0] REG_MAX_ELEV   = 3'd2;
   localparam logic [2:0] REG_CELLS_PM   = 3'd3;
   localparam logic [2:0] REG_MAP_WIDTH  = 3'd4;
   localparam logic [2:0] REG_MAP_HEIGHT = 3'd5;
   localparam logic [2:0] REG_UNKNOWN    = 3'd6;

   localparam logic signed [31:0] UNKNOWN_RESET = 32'sh8000_0000;

   typedef struct packed {
      logic [30:0]        max_dist;
      logic signed [31:0] min_elev;
      logic signed [31:0] max_elev;
      logic [15:0]        cells_per_meter;
      logic [8:0]         map_width;
      logic [8:0]         map_height;
      logic signed [31:0] unknown_value;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      max_dist:        31'd262144,
      min_elev:        32'shFFFF_8000,
      max_elev:        32'sd65536,
      cells_per_meter: 16'd2560,
      map_width:       9'd256,
      map_height:      9'd256,
      unknown_value:   UNKNOWN_RESET
   };

   // OP_DIRECT: result fully known in the front, back just reports it
   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_READ   = 2'd2,
      OP_DIRECT = 2'd3
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [2:0]         status;
      logic signed [31:0] value;
      logic [7:0]         col;
      logic [7:0]         row;
   } entry_type;

endpackage
`default_nettype wire

>>> hw/rtl/mhgb_ram.sv
`default_nettype none
module mhgb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> hw/rtl/mhgb_queue.sv
`default_nettype none
module mhgb_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  empty,
   output logic      [CW-1:0]    count
);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign do_push = push && (count_ff != CW'(DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata = data_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;

endmodule
`default_nettype wire

>>> hw/rtl/mhgb_front.sv
`default_nettype none
module mhgb_front #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 256,
   localparam int COL_W  = $clog2(MAX_COLS),
   localparam int ROW_W  = $clog2(MAX_ROWS),
   localparam int ADDR_W = COL_W + ROW_W
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [1:0]           cmd,
   input  wire logic signed [31:0]   point_x,
   input  wire logic signed [31:0]   point_y,
   input  wire logic signed [31:0]   point_z,
   input  wire logic signed [31:0]   sensor_depth,
   input  wire logic                 point_ok,
   input  wire logic [7:0]           read_col,
   input  wire logic [7:0]           read_row,
   input  wire mhgb_pkg::cfg_type    cfg,
   output logic [1:0]                flight,
   output logic                      push,
   output mhgb_pkg::entry_type       entry,
   output logic [ADDR_W-1:0]         addr
);

   // stage 1: captured item
   logic               s1_v_ff;
   logic [1:0]         s1_cmd_ff;
   logic signed [31:0] s1_x_ff, s1_y_ff, s1_z_ff, s1_depth_ff;
   logic               s1_ok_ff;
   logic [7:0]         s1_rcol_ff, s1_rrow_ff;

   // stage 2: classified, products registered
   logic                s2_v_ff;
   mhgb_pkg::entry_type s2_entry_ff, s2_entry_in;
   logic [ADDR_W-1:0]   s2_addr_ff, s2_addr_in;
   logic signed [48:0]  s2_prod_x_ff, s2_prod_x_in;
   logic signed [48:0]  s2_prod_y_ff, s2_prod_y_in;

   logic               too_far, height_out, in_storage;
   logic [49:0]        sum_x, sum_y;
   logic [25:0]        col, row;
   logic               off_grid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= accept;
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff   <= cmd;
         s1_x_ff     <= point_x;
         s1_y_ff     <= point_y;
         s1_z_ff     <= point_z;
         s1_depth_ff <= sensor_depth;
         s1_ok_ff    <= point_ok;
         s1_rcol_ff  <= read_col;
         s1_rrow_ff  <= read_row;
      end
      s2_entry_ff  <= s2_entry_in;
      s2_addr_ff   <= s2_addr_in;
      s2_prod_x_ff <= s2_prod_x_in;
      s2_prod_y_ff <= s2_prod_y_in;
   end

   assign too_far    = s1_depth_ff > $signed({1'b0, cfg.max_dist});
   assign height_out = (s1_z_ff < cfg.min_elev) || (s1_z_ff > cfg.max_elev);
   assign in_storage = (32'(s1_rcol_ff) < 32'(MAX_COLS)) &&
                       (32'(s1_rrow_ff) < 32'(MAX_ROWS));

   assign s2_prod_x_in = 49'(s1_x_ff) * 49'($signed({1'b0, cfg.cells_per_meter}));
   assign s2_prod_y_in = 49'(s1_y_ff) * 49'($signed({1'b0, cfg.cells_per_meter}));

   always_comb begin
      s2_entry_in = '0;
      s2_addr_in  = '0;
      case (s1_cmd_ff)
         mhgb_pkg::CMD_CLEAR: begin
            s2_entry_in.op     = mhgb_pkg::OP_CLEAR;
            s2_entry_in.status = mhgb_pkg::STS_CLEARED;
         end
         mhgb_pkg::CMD_INSERT: begin
            s2_entry_in.op = mhgb_pkg::OP_DIRECT;
            if (!s1_ok_ff) begin
               s2_entry_in.status = mhgb_pkg::STS_INVALID;
            end else if (too_far) begin
               s2_entry_in.status = mhgb_pkg::STS_TOO_FAR;
            end else if (height_out) begin
               s2_entry_in.status = mhgb_pkg::STS_HEIGHT_OUT;
            end else begin
               s2_entry_in.op     = mhgb_pkg::OP_INSERT;
               s2_entry_in.status = mhgb_pkg::STS_UPDATED;
               s2_entry_in.value  = s1_z_ff;
            end
         end
         default: begin
            // read; an undefined command reads too
            s2_entry_in.status = mhgb_pkg::STS_READ;
            s2_entry_in.col    = s1_rcol_ff;
            s2_entry_in.row    = s1_rrow_ff;
            if (in_storage) begin
               s2_entry_in.op = mhgb_pkg::OP_READ;
               s2_addr_in     = {ROW_W'(s1_rrow_ff), COL_W'(s1_rcol_ff)};
            end else begin
               s2_entry_in.op    = mhgb_pkg::OP_DIRECT;
               s2_entry_in.value = cfg.unknown_value;
            end
         end
      endcase
   end

   // index = floor((coord*scale + size*2^23) / 2^24), exact
   assign sum_x = {s2_prod_x_ff[48], s2_prod_x_ff} + {18'd0, cfg.map_width, 23'd0};
   assign sum_y = {s2_prod_y_ff[48], s2_prod_y_ff} + {18'd0, cfg.map_height, 23'd0};
   assign col   = sum_x[49:24];
   assign row   = sum_y[49:24];

   assign off_grid = col[25] || (col[24:0] >= 25'(cfg.map_width)) ||
                     (col[24:0] >= 25'(MAX_COLS)) ||
                     row[25] || (row[24:0] >= 25'(cfg.map_height)) ||
                     (row[24:0] >= 25'(MAX_ROWS));

   always_comb begin
      entry = s2_entry_ff;
      addr  = s2_addr_ff;
      if (s2_entry_ff.op == mhgb_pkg::OP_INSERT) begin
         if (off_grid) begin
            entry        = '0;
            entry.op     = mhgb_pkg::OP_DIRECT;
            entry.status = mhgb_pkg::STS_OFF_GRID;
         end else begin
            entry.col = col[7:0];
            entry.row = row[7:0];
            addr      = {row[ROW_W-1:0], col[COL_W-1:0]};
         end
      end
   end

   assign push   = s2_v_ff;
   assign flight = {1'b0, s1_v_ff} + {1'b0, s2_v_ff};

endmodule
`default_nettype wire

>>> hw/rtl/mhgb_back.sv
`default_nettype none
module mhgb_back #(
   parameter int ADDR_W = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mhgb_pkg::cfg_type   cfg,
   input  wire logic                q_empty,
   input  wire mhgb_pkg::entry_type q_entry,
   input  wire logic [ADDR_W-1:0]   q_addr,
   output logic                     q_pop,
   output logic                     init_busy,
   output logic                     rsp_valid,
   output logic [2:0]               rsp_status,
   output logic signed [31:0]       rsp_cell_value,
   output logic [7:0]               rsp_cell_col,
   output logic [7:0]               rsp_cell_row
);

   localparam int DEPTH = 1 << ADDR_W;
   localparam logic [ADDR_W-1:0] ADDR_LAST = '1;

   typedef enum logic [2:0] {
      BK_IDLE  = 3'b001,
      BK_WAIT  = 3'b010,
      BK_SWEEP = 3'b100
   } back_state_type;

   back_state_type      state_ff, state_in;
   mhgb_pkg::entry_type cur_ff, cur_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [ADDR_W-1:0]   sweep_ff, sweep_in;
   logic signed [31:0]  fill_ff, fill_in;
   logic                init_ff, init_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic [7:0]         rsp_col_ff, rsp_col_in;
   logic [7:0]         rsp_row_ff, rsp_row_in;

   logic               we;
   logic [ADDR_W-1:0]  waddr;
   logic [31:0]        wdata;
   logic [31:0]        rdata;

   mhgb_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (q_addr),
      .rdata (rdata)
   );

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      addr_in       = addr_ff;
      sweep_in      = sweep_ff;
      fill_in       = fill_ff;
      init_in       = init_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      q_pop         = 1'b0;
      we            = 1'b0;
      waddr         = addr_ff;
      wdata         = cur_ff.value;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               cur_in  = q_entry;
               addr_in = q_addr;
               case (q_entry.op)
                  mhgb_pkg::OP_CLEAR: begin
                     state_in = BK_SWEEP;
                     sweep_in = '0;
                     fill_in  = cfg.unknown_value;
                  end
                  mhgb_pkg::OP_INSERT, mhgb_pkg::OP_READ: begin
                     // grid read issued at q_addr this cycle
                     state_in = BK_WAIT;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = q_entry.status;
                     rsp_value_in  = q_entry.value;
                     rsp_col_in    = q_entry.col;
                     rsp_row_in    = q_entry.row;
                  end
               endcase
            end
         end
         BK_WAIT: begin
            state_in     = BK_IDLE;
            rsp_valid_in = 1'b1;
            rsp_col_in   = cur_ff.col;
            rsp_row_in   = cur_ff.row;
            rsp_value_in = $signed(rdata);
            if (cur_ff.op == mhgb_pkg::OP_INSERT) begin
               if (cur_ff.value > $signed(rdata)) begin
                  we            = 1'b1;
                  rsp_status_in = mhgb_pkg::STS_UPDATED;
                  rsp_value_in  = cur_ff.value;
               end else begin
                  rsp_status_in = mhgb_pkg::STS_NOT_HIGHER;
               end
            end else begin
               rsp_status_in = mhgb_pkg::STS_READ;
            end
         end
         BK_SWEEP: begin
            we       = 1'b1;
            waddr    = sweep_ff;
            wdata    = fill_ff;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == ADDR_LAST) begin
               state_in = BK_IDLE;
               init_in  = 1'b0;
               if (!init_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = mhgb_pkg::STS_CLEARED;
                  rsp_value_in  = fill_ff;
                  rsp_col_in    = '0;
                  rsp_row_in    = '0;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_SWEEP;
         sweep_ff     <= '0;
         fill_ff      <= mhgb_pkg::UNKNOWN_RESET;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         fill_ff      <= fill_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      addr_ff       <= addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_row_ff    <= rsp_row_in;
   end

   assign init_busy      = init_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_cell_value = rsp_value_ff;
   assign rsp_cell_col   = rsp_col_ff;
   assign rsp_cell_row   = rsp_row_ff;

endmodule
`default_nettype wire

>>> hw/rtl/max_height_grid_binner_unit.sv
// Max-height elevation grid. start/busy take one command per cycle, while busy
// is low, into a two-stage front (depth/height checks, scale multiply, cell
// index and bounds) that feeds a four-entry queue; the back end owns the grid
// RAM, one write and one registered read port. Insert and in-storage read
// first read the grid, then compare and write back; dropped points and reads
// outside storage are reported without a grid access. Clear writes every RAM
// row once, 2^(clog2(MAX_COLS)+clog2(MAX_ROWS)) rows, 65536 at the defaults.
// The same clearing pass runs after reset with busy high. Results appear in
// order, each on rsp_valid for one cycle; the receiver cannot stall, so it
// must take every strobe. busy rises when the queue could not absorb the items
// already in the front.
`default_nettype none
module max_height_grid_binner_unit #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_cmd,
   input  wire logic signed [31:0] req_point_x,
   input  wire logic signed [31:0] req_point_y,
   input  wire logic signed [31:0] req_point_z,
   input  wire logic signed [31:0] req_sensor_depth,
   input  wire logic               req_point_ok,
   input  wire logic [7:0]         req_read_col,
   input  wire logic [7:0]         req_read_row,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_status,
   output logic signed [31:0]      rsp_cell_value,
   output logic [7:0]              rsp_cell_col,
   output logic [7:0]              rsp_cell_row,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);

   localparam int ADDR_W  = $clog2(MAX_COLS) + $clog2(MAX_ROWS);
   localparam int Q_DEPTH = 4;
   localparam int Q_CW    = $clog2(Q_DEPTH + 1);
   localparam int SUM_W   = Q_CW + 1;
   localparam int Q_W     = $bits(mhgb_pkg::entry_type) + ADDR_W;

   mhgb_pkg::cfg_type   cfg_ff, cfg_in;
   mhgb_pkg::entry_type push_entry, head_entry;
   logic [ADDR_W-1:0]   push_addr, head_addr;
   logic [Q_W-1:0]      q_rdata;
   logic [Q_CW-1:0]     q_count;
   logic [1:0]          flight;
   logic                push, pop, q_empty, init_busy, accept;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            mhgb_pkg::REG_MAX_DIST:   cfg_in.max_dist        = csr_wdata[30:0];
            mhgb_pkg::REG_MIN_ELEV:   cfg_in.min_elev        = $signed(csr_wdata);
            mhgb_pkg::REG_MAX_ELEV:   cfg_in.max_elev        = $signed(csr_wdata);
            mhgb_pkg::REG_CELLS_PM:   cfg_in.cells_per_meter = csr_wdata[15:0];
            mhgb_pkg::REG_MAP_WIDTH:  cfg_in.map_width       = csr_wdata[8:0];
            mhgb_pkg::REG_MAP_HEIGHT: cfg_in.map_height      = csr_wdata[8:0];
            mhgb_pkg::REG_UNKNOWN:    cfg_in.unknown_value   = $signed(csr_wdata);
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= mhgb_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // reserve a queue slot for every item still in the front
   assign busy = init_busy ||
                 (({1'b0, q_count} + SUM_W'(flight)) >= SUM_W'(Q_DEPTH));
   assign accept = start && !busy;

   mhgb_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .cmd          (req_cmd),
      .point_x      (req_point_x),
      .point_y      (req_point_y),
      .point_z      (req_point_z),
      .sensor_depth (req_sensor_depth),
      .point_ok     (req_point_ok),
      .read_col     (req_read_col),
      .read_row     (req_read_row),
      .cfg          (cfg_ff),
      .flight       (flight),
      .push         (push),
      .entry        (push_entry),
      .addr         (push_addr)
   );

   mhgb_queue #(
      .WIDTH (Q_W),
      .DEPTH (Q_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata ({push_entry, push_addr}),
      .pop   (pop),
      .rdata (q_rdata),
      .empty (q_empty),
      .count (q_count)
   );

   assign {head_entry, head_addr} = q_rdata;

   mhgb_back #(
      .ADDR_W (ADDR_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_empty        (q_empty),
      .q_entry        (head_entry),
      .q_addr         (head_addr),
      .q_pop          (pop),
      .init_busy      (init_busy),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_cell_value (rsp_cell_value),
      .rsp_cell_col   (rsp_cell_col),
      .rsp_cell_row   (rsp_cell_row)
   );

endmodule
`default_nettype wire
